// ===== rtl/asd_pkg.sv =====
// ---------------------------------------------------------------------------
// asd_pkg
// Shared types and constants for the accelerometer shake detector: command
// and status structures between controller and datapath, and the
// controller state encoding.
// ---------------------------------------------------------------------------
package asd_pkg;

  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned ROOT_W     = 16;
  localparam int unsigned REM_W      = ROOT_W + 1;
  localparam int unsigned ROOT_STEPS = ROOT_W;
  localparam int unsigned CNT_W      = $clog2(ROOT_STEPS);
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [ROOT_W-1:0] ONE_G_Q12 = 16'd4096;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_PRESENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN       = 2'd3;

  // Axis selection for the shared squarer
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(2);
  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ACC,
    ST_ROOT,
    ST_EVAL
  } asd_state_t;

  typedef struct packed {
    logic       load;       // capture a new sample
    logic       sq_en;      // square the selected axis
    logic [1:0] sq_sel;     // axis to square
    logic       acc_en;     // add the previous square into the sum
    logic       root_init;  // finish the sum and start the square root
    logic       root_step;  // one result bit of the square root
    logic       eval;       // decide, update state and fill the output
  } asd_cmd_t;

  typedef struct packed {
    logic out_free;         // output register can take a result this cycle
  } asd_sts_t;

endpackage

// ===== rtl/accel_shake_detector_unit.sv =====
// ---------------------------------------------------------------------------
// accel_shake_detector_unit
// Accelerometer shake detector with cooldown and a pending-alert latch:
// magnitude by floor square root of the sum of squares, dynamic part as the
// distance from 1 g, and a shake decision gated by enables, busy and cooldown.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Contents
//  --------+-----------+----------------------+--------------------------------
//  in_     | slave     | in_tvalid/in_tready  | one sample with timestamp and flags
//  out_    | master    | out_tvalid/out_tready| one decision per sample
//  cfg_    | write     | cfg_we               | four configuration registers
//
// A sample goes through the shared 16x16 squarer, one step to close the sum,
// the bit-serial square root (one result bit per cycle) and the decision
// before the next sample is accepted. The result is presented in the cycle
// after the decision.
// A sample may be accepted while an earlier result still waits on out_tready;
// only the decision step waits for the output register to empty.
// Reset is synchronous and active low; it restores the register defaults and
// clears the alert latch and the time of the last shake.
//
module accel_shake_detector_unit
  import asd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Sample stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [79:48] now_ms,
  // [80] measure_busy, [81] clear_pending, [87:82] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] shake_detected, [16:1] magnitude_q12, [32:17] dynamic_q12,
  // [33] pending_valid, [49:34] pending_magnitude, [65:50] pending_dynamic,
  // [71:66] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  asd_cmd_t cmd;
  asd_sts_t sts;

  // The controller sequences one sample at a time and holds off new
  // transactions until the decision for the current sample is made.
  asd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, the arithmetic, the detector
  // state and the output register that decouples the result stream.
  asd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/asd_ctrl.sv =====
// ---------------------------------------------------------------------------
// asd_ctrl
// Sequencer for the shake detector: walks one sample through squaring,
// summation, the bit-serial square root and the final decision.
// ---------------------------------------------------------------------------
module asd_ctrl
  import asd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  asd_sts_t sts,
  output asd_cmd_t cmd
);

  asd_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (cnt_r == SQ_LAST) begin
          state_nxt = ST_ACC;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ACC: begin
        state_nxt = ST_ROOT;
        cnt_nxt   = '0;
      end
      ST_ROOT: begin
        if (cnt_r == ROOT_LAST) begin
          state_nxt = ST_EVAL;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_EVAL: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SQ: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = cnt_r[1:0];
        cmd.acc_en = (cnt_r != '0);
      end
      ST_ACC: begin
        cmd.root_init = 1'b1;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
      end
      ST_EVAL: begin
        cmd.eval = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.sq_en, cmd.root_init, cmd.root_step, cmd.eval}))
    else $error("asd_ctrl: more than one datapath phase commanded");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_SQ && cnt_r == '0))
    else $error("asd_ctrl: accepted sample did not start squaring");

  a_root_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT && cnt_r == ROOT_LAST) |=> (state_r == ST_EVAL))
    else $error("asd_ctrl: square root did not end after its last step");
`endif

endmodule

// ===== rtl/asd_dp.sv =====
// ---------------------------------------------------------------------------
// asd_dp
// Datapath of the shake detector: configuration registers, shared squarer,
// sum accumulator, bit-serial square root, decision logic, alert latch and
// the output register.
// ---------------------------------------------------------------------------
module asd_dp
  import asd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  asd_cmd_t              cmd,
  output asd_sts_t              sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // Configuration
  logic              shake_enable_r;
  logic              sensor_present_r;
  logic [ROOT_W-1:0] threshold_r;
  logic [15:0]       cooldown_r;

  // Sample
  logic [AXIS_W-1:0] ax_r, ay_r, az_r;
  logic [TIME_W-1:0] now_r;
  logic              busy_r, clr_r;

  // Arithmetic
  logic [SUM_W-1:0]  prod_r, sum_r, src_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;

  // Detector state
  logic [TIME_W-1:0] last_shake_r;
  logic              pending_r;
  logic [ROOT_W-1:0] lat_mag_r, lat_dyn_r;

  // Output register
  logic              out_valid_r;
  logic              o_shake_r, o_pv_r;
  logic [ROOT_W-1:0] o_mag_r, o_dyn_r, o_pmag_r, o_pdyn_r;

  function automatic logic [AXIS_W-1:0] abs16(input logic [AXIS_W-1:0] v);
    logic [AXIS_W-1:0] r;
    r = v[AXIS_W-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shake_enable_r   <= 1'b1;
      sensor_present_r <= 1'b0;
      threshold_r      <= 16'd4506;
      cooldown_r       <= 16'd2000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHAKE_ENABLE:   shake_enable_r   <= cfg_data[0];
        CFG_SENSOR_PRESENT: sensor_present_r <= cfg_data[0];
        CFG_THRESHOLD:      threshold_r      <= cfg_data;
        CFG_COOLDOWN:       cooldown_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r   <= abs16(in_tdata[15:0]);
      ay_r   <= abs16(in_tdata[31:16]);
      az_r   <= abs16(in_tdata[47:32]);
      now_r  <= in_tdata[79:48];
      busy_r <= in_tdata[80];
      clr_r  <= in_tdata[81];
    end
  end

  // Squarer and accumulator
  logic [AXIS_W-1:0] sq_in;
  always_comb begin
    case (cmd.sq_sel)
      AXIS_X:  sq_in = ax_r;
      AXIS_Y:  sq_in = ay_r;
      AXIS_Z:  sq_in = az_r;
      default: sq_in = ax_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      prod_r <= sq_in * sq_in;
    end
    if (cmd.load) begin
      sum_r <= '0;
    end else if (cmd.acc_en) begin
      sum_r <= sum_r + prod_r;
    end
  end

  // Square root, one result bit per step
  logic [REM_W+1:0] rem_sh, trial;
  logic             fits;
  assign rem_sh = {rem_r, src_r[SUM_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      src_r  <= sum_r + prod_r;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      src_r  <= {src_r[SUM_W-3:0], 2'b00};
      rem_r  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
  end

  // Decision
  logic [ROOT_W-1:0] dyn;
  logic [TIME_W-1:0] elapsed;
  logic              shake;
  logic              pend_base;
  logic              pend_nxt;
  logic [ROOT_W-1:0] lat_mag_nxt, lat_dyn_nxt;

  assign dyn     = (root_r >= ONE_G_Q12) ? (root_r - ONE_G_Q12) : (ONE_G_Q12 - root_r);
  assign elapsed = now_r - last_shake_r;
  assign shake   = shake_enable_r && sensor_present_r && !busy_r &&
                   (dyn >= threshold_r) && (elapsed >= TIME_W'(cooldown_r));
  assign pend_base = clr_r ? 1'b0 : pending_r;

  always_comb begin
    pend_nxt    = pend_base;
    lat_mag_nxt = clr_r ? '0 : lat_mag_r;
    lat_dyn_nxt = clr_r ? '0 : lat_dyn_r;
    if (shake && !pend_base) begin
      pend_nxt    = 1'b1;
      lat_mag_nxt = root_r;
      lat_dyn_nxt = dyn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_shake_r <= '0;
      pending_r    <= 1'b0;
      lat_mag_r    <= '0;
      lat_dyn_r    <= '0;
    end else if (cmd.eval) begin
      if (shake) begin
        last_shake_r <= now_r;
      end
      pending_r <= pend_nxt;
      lat_mag_r <= lat_mag_nxt;
      lat_dyn_r <= lat_dyn_nxt;
    end
  end

  // Output register
  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.eval) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      o_shake_r <= shake;
      o_mag_r   <= root_r;
      o_dyn_r   <= dyn;
      o_pv_r    <= pend_nxt;
      o_pmag_r  <= pend_nxt ? lat_mag_nxt : '0;
      o_pdyn_r  <= pend_nxt ? lat_dyn_nxt : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, o_pdyn_r, o_pmag_r, o_pv_r, o_dyn_r, o_mag_r, o_shake_r};

`ifndef SYNTHESIS
  a_latch_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !pending_r |-> (lat_mag_r == '0 && lat_dyn_r == '0))
    else $error("asd_dp: latched values non-zero without a pending alert");

  a_shake_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!o_shake_r || o_pv_r))
    else $error("asd_dp: shake reported without a pending alert");

  a_no_pending_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !o_pv_r) |-> (o_pmag_r == '0 && o_pdyn_r == '0))
    else $error("asd_dp: pending fields non-zero with no pending alert");

  a_time_recorded: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval && shake) |=> (last_shake_r == $past(now_r)))
    else $error("asd_dp: shake time not recorded");
`endif

endmodule
